/* hw/rtl/bra_pkg.sv */
// ----------------------------------------------------------------------------
// bra_pkg
// Shared constants, codes and types for the deadlock-avoidance allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bra_pkg;

    localparam int CLIENTS_DEF    = 4;
    localparam int RTYPES_DEF     = 4;
    localparam int UNIT_BITS_DEF  = 8;

    localparam int MAX_RTYPES     = 4;
    localparam int KIND_W         = 2;
    localparam int IDX_W          = 2;
    localparam int AMT_W          = 8;
    localparam int STATUS_W       = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_REQUEST = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_CLAIM   = 2'd2,
        KIND_POOL    = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED    = 3'd0,
        ST_OVER_CLAIM = 3'd1,
        ST_OVER_FREE  = 3'd2,
        ST_UNSAFE     = 3'd3,
        ST_RELEASED   = 3'd4,
        ST_CLAIM_SET  = 3'd5,
        ST_POOL_SET   = 3'd6,
        ST_REJECTED   = 3'd7
    } status_t;

    typedef struct packed {
        logic held_we;
        logic need_we;
    } store_wr_t;

endpackage

`default_nettype wire

/* hw/rtl/bra_if.sv */
// ----------------------------------------------------------------------------
// bra_if
// Valid/ready channels for allocator commands and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface bra_cmd_if
    import bra_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  process_index;
    logic [AMT_W-1:0]  amount_r0;
    logic [AMT_W-1:0]  amount_r1;
    logic [AMT_W-1:0]  amount_r2;
    logic [AMT_W-1:0]  amount_r3;

    modport source (
        output valid, kind, process_index, amount_r0, amount_r1, amount_r2, amount_r3,
        input  ready
    );
    modport sink (
        input  valid, kind, process_index, amount_r0, amount_r1, amount_r2, amount_r3,
        output ready
    );
endinterface

interface bra_rsp_if
    import bra_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [AMT_W-1:0]    free_r0;
    logic [AMT_W-1:0]    free_r1;
    logic [AMT_W-1:0]    free_r2;
    logic [AMT_W-1:0]    free_r3;

    modport source (
        output valid, status, free_r0, free_r1, free_r2, free_r3,
        input  ready
    );
    modport sink (
        input  valid, status, free_r0, free_r1, free_r2, free_r3,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/bra_alu.sv */
// ----------------------------------------------------------------------------
// bra_alu
// Shared vector unit: per-type compare, saturating add and wrapping subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_alu
    import bra_pkg::*;
#(
    parameter int RESOURCE_TYPES = RTYPES_DEF,
    parameter int UNIT_BITS      = UNIT_BITS_DEF
) (
    input  logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] cmp_x,
    input  logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] cmp_y,
    input  logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] add_x,
    input  logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] add_y,
    output logic [RESOURCE_TYPES-1:0]                gt,
    output logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] sum,
    output logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] diff
);

    localparam logic [UNIT_BITS-1:0] UNIT_MAX = '1;

    for (genvar r = 0; r < RESOURCE_TYPES; r++) begin : g_lane
        logic [UNIT_BITS:0] raw;
        assign raw     = {1'b0, add_x[r]} + {1'b0, add_y[r]};
        assign sum[r]  = raw[UNIT_BITS] ? UNIT_MAX : raw[UNIT_BITS-1:0];
        assign diff[r] = add_y[r] - add_x[r];
        assign gt[r]   = cmp_x[r] > cmp_y[r];
    end

endmodule

`default_nettype wire

/* hw/rtl/bra_store.sv */
// ----------------------------------------------------------------------------
// bra_store
// Per-client holdings and remaining need, one row port shared by all steps.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_store
    import bra_pkg::*;
#(
    parameter int CLIENTS        = CLIENTS_DEF,
    parameter int RESOURCE_TYPES = RTYPES_DEF,
    parameter int UNIT_BITS      = UNIT_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [$clog2(CLIENTS)-1:0]               addr,
    input  store_wr_t                                wr,
    input  logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] held_wdata,
    input  logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] need_wdata,
    output logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] held_rdata,
    output logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] need_rdata
);

    logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] held_reg [CLIENTS];
    logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] need_reg [CLIENTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CLIENTS; c++)
            begin
                held_reg[c] <= '0;
                need_reg[c] <= '0;
            end
        end
        else
        begin
            if (wr.held_we)
            begin
                held_reg[addr] <= held_wdata;
            end
            if (wr.need_we)
            begin
                need_reg[addr] <= need_wdata;
            end
        end
    end

    assign held_rdata = held_reg[addr];
    assign need_rdata = need_reg[addr];

endmodule

`default_nettype wire

/* hw/rtl/bankers_resource_allocator_top.sv */
// ----------------------------------------------------------------------------
// bankers_resource_allocator_top
// Banker's deadlock-avoidance allocator: sequencer over a shared vector unit.
// ----------------------------------------------------------------------------
// steps: a pool command walks every client; a request checks, applies the grant,
//   then scans the clients one at a time for a safe order and rolls the grant
//   back when none is found
// throughput: one item at a time, next beat taken the cycle after the result
//   is loaded into the response register
// reset: all holdings, needs and free units clear to zero, no response pending
`default_nettype none

module bankers_resource_allocator_top
    import bra_pkg::*;
#(
    parameter int CLIENTS        = CLIENTS_DEF,
    parameter int RESOURCE_TYPES = RTYPES_DEF,
    parameter int UNIT_BITS      = UNIT_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    bra_cmd_if.sink  cmd,
    bra_rsp_if.source rsp
);

    localparam int CW = $clog2(CLIENTS);
    localparam logic [UNIT_BITS-1:0] UNIT_MAX = '1;

    typedef logic [RESOURCE_TYPES-1:0][UNIT_BITS-1:0] uvec_t;

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_POOL     = 15'h0002,
        S_CLAIM    = 15'h0004,
        S_REQ_CHK  = 15'h0008,
        S_REQ_FREE = 15'h0010,
        S_REQ_NEED = 15'h0020,
        S_REQ_HELD = 15'h0040,
        S_SCAN     = 15'h0080,
        S_RB_FREE  = 15'h0100,
        S_RB_NEED  = 15'h0200,
        S_RB_HELD  = 15'h0400,
        S_REL_CHK  = 15'h0800,
        S_REL_NEED = 15'h1000,
        S_REL_FREE = 15'h2000,
        S_FINISH   = 15'h4000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      prog_reg, prog_next;
    logic [CLIENTS-1:0]        done_reg, done_next;
    uvec_t                     work_reg, work_next;
    uvec_t                     free_reg, free_next;
    status_t                   status_reg, status_next;
    logic [CW-1:0]             idx_reg, idx_next;
    uvec_t                     amt_reg, amt_next;
    logic [RESOURCE_TYPES-1:0] over_reg, over_next;
    logic                      out_valid_reg;
    status_t                   out_status_reg;
    uvec_t                     out_free_reg;

    logic [AMT_W-1:0]          amt_in [MAX_RTYPES];
    uvec_t                     in_sat;
    logic [RESOURCE_TYPES-1:0] in_over;
    logic [CW+IDX_W-1:0]       idx_wide;
    logic                      idx_ok;
    logic                      accept;
    logic                      out_load;

    uvec_t                     cmp_x, cmp_y, add_x, add_y, sum, diff;
    logic [RESOURCE_TYPES-1:0] gt;
    logic                      any_gt, any_gt_over, fit, prog_now;
    uvec_t                     held_rd, need_rd, held_wd, need_wd;
    store_wr_t                 wr;
    logic [CW-1:0]             store_addr;
    logic [MAX_RTYPES-1:0][AMT_W-1:0] free_out;

    // input lanes
    assign amt_in[0] = cmd.amount_r0;
    assign amt_in[1] = cmd.amount_r1;
    assign amt_in[2] = cmd.amount_r2;
    assign amt_in[3] = cmd.amount_r3;

    for (genvar r = 0; r < RESOURCE_TYPES; r++) begin : g_in
        logic [UNIT_BITS+AMT_W-1:0] amt_w;
        assign amt_w      = {{UNIT_BITS{1'b0}}, amt_in[r]};
        assign in_over[r] = amt_w > {{AMT_W{1'b0}}, UNIT_MAX};
        assign in_sat[r]  = in_over[r] ? UNIT_MAX : amt_w[UNIT_BITS-1:0];
    end

    assign idx_wide = {{CW{1'b0}}, cmd.process_index};
    assign idx_ok   = 32'(cmd.process_index) < 32'(CLIENTS);

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);

    bra_alu #(
        .RESOURCE_TYPES (RESOURCE_TYPES),
        .UNIT_BITS      (UNIT_BITS)
    ) u_alu (
        .cmp_x (cmp_x),
        .cmp_y (cmp_y),
        .add_x (add_x),
        .add_y (add_y),
        .gt    (gt),
        .sum   (sum),
        .diff  (diff)
    );

    bra_store #(
        .CLIENTS        (CLIENTS),
        .RESOURCE_TYPES (RESOURCE_TYPES),
        .UNIT_BITS      (UNIT_BITS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .addr       (store_addr),
        .wr         (wr),
        .held_wdata (held_wd),
        .need_wdata (need_wd),
        .held_rdata (held_rd),
        .need_rdata (need_rd)
    );

    assign store_addr  = (state_reg == S_POOL || state_reg == S_SCAN) ? cnt_reg : idx_reg;
    assign any_gt      = |gt;
    assign any_gt_over = |(gt | over_reg);
    assign fit         = !done_reg[cnt_reg] && !any_gt;
    assign prog_now    = prog_reg || fit;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        prog_next   = prog_reg;
        done_next   = done_reg;
        work_next   = work_reg;
        free_next   = free_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        amt_next    = amt_reg;
        over_next   = over_reg;
        cmp_x       = amt_reg;
        cmp_y       = need_rd;
        add_x       = amt_reg;
        add_y       = need_rd;
        held_wd     = diff;
        need_wd     = diff;
        wr          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next  = idx_wide[CW-1:0];
                    amt_next  = in_sat;
                    over_next = in_over;
                    cnt_next  = '0;
                    if (cmd.kind == KIND_POOL)
                    begin
                        free_next  = in_sat;
                        state_next = S_POOL;
                    end
                    else if (!idx_ok)
                    begin
                        status_next = ST_REJECTED;
                        state_next  = S_FINISH;
                    end
                    else if (cmd.kind == KIND_REQUEST)
                    begin
                        state_next = S_REQ_CHK;
                    end
                    else if (cmd.kind == KIND_RELEASE)
                    begin
                        state_next = S_REL_CHK;
                    end
                    else
                    begin
                        state_next = S_CLAIM;
                    end
                end
            end
            S_POOL:
            begin
                add_x       = held_rd;
                add_y       = need_rd;
                need_wd     = sum;
                held_wd     = '0;
                wr.need_we  = 1'b1;
                wr.held_we  = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CW'(CLIENTS - 1))
                begin
                    status_next = ST_POOL_SET;
                    state_next  = S_FINISH;
                end
            end
            S_CLAIM:
            begin
                cmp_x = held_rd;
                cmp_y = amt_reg;
                add_x = held_rd;
                add_y = amt_reg;
                if (any_gt)
                begin
                    status_next = ST_REJECTED;
                end
                else
                begin
                    need_wd     = diff;
                    wr.need_we  = 1'b1;
                    status_next = ST_CLAIM_SET;
                end
                state_next = S_FINISH;
            end
            S_REQ_CHK:
            begin
                if (any_gt_over)
                begin
                    status_next = ST_OVER_CLAIM;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_REQ_FREE;
                end
            end
            S_REQ_FREE:
            begin
                cmp_y = free_reg;
                add_y = free_reg;
                if (any_gt_over)
                begin
                    status_next = ST_OVER_FREE;
                    state_next  = S_FINISH;
                end
                else
                begin
                    free_next  = diff;
                    state_next = S_REQ_NEED;
                end
            end
            S_REQ_NEED:
            begin
                need_wd    = diff;
                wr.need_we = 1'b1;
                state_next = S_REQ_HELD;
            end
            S_REQ_HELD:
            begin
                add_y      = held_rd;
                held_wd    = sum;
                wr.held_we = 1'b1;
                work_next  = free_reg;
                done_next  = '0;
                prog_next  = 1'b0;
                cnt_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmp_x = need_rd;
                cmp_y = work_reg;
                add_x = held_rd;
                add_y = work_reg;
                if (fit)
                begin
                    work_next          = sum;
                    done_next[cnt_reg] = 1'b1;
                end
                if (&done_next)
                begin
                    status_next = ST_GRANTED;
                    state_next  = S_FINISH;
                end
                else if (cnt_reg == CW'(CLIENTS - 1))
                begin
                    cnt_next  = '0;
                    prog_next = 1'b0;
                    if (!prog_now)
                    begin
                        state_next = S_RB_FREE;
                    end
                end
                else
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    prog_next = prog_now;
                end
            end
            S_RB_FREE:
            begin
                add_y      = free_reg;
                free_next  = sum;
                state_next = S_RB_NEED;
            end
            S_RB_NEED:
            begin
                need_wd    = sum;
                wr.need_we = 1'b1;
                state_next = S_RB_HELD;
            end
            S_RB_HELD:
            begin
                add_y       = held_rd;
                held_wd     = diff;
                wr.held_we  = 1'b1;
                status_next = ST_UNSAFE;
                state_next  = S_FINISH;
            end
            S_REL_CHK:
            begin
                cmp_y = held_rd;
                add_y = held_rd;
                if (any_gt_over)
                begin
                    status_next = ST_REJECTED;
                    state_next  = S_FINISH;
                end
                else
                begin
                    held_wd    = diff;
                    wr.held_we = 1'b1;
                    state_next = S_REL_NEED;
                end
            end
            S_REL_NEED:
            begin
                need_wd    = sum;
                wr.need_we = 1'b1;
                state_next = S_REL_FREE;
            end
            S_REL_FREE:
            begin
                add_y       = free_reg;
                free_next   = sum;
                status_next = ST_RELEASED;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            prog_reg      <= 1'b0;
            done_reg      <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            prog_reg  <= prog_next;
            done_reg  <= done_next;
            free_reg  <= free_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        amt_reg    <= amt_next;
        over_reg   <= over_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_free_reg   <= free_reg;
        end
    end

    // response lanes, unused types read zero
    for (genvar r = 0; r < MAX_RTYPES; r++) begin : g_out
        if (r < RESOURCE_TYPES) begin : g_used
            logic [UNIT_BITS+AMT_W-1:0] free_w;
            assign free_w      = {{AMT_W{1'b0}}, out_free_reg[r]};
            assign free_out[r] = free_w[AMT_W-1:0];
        end
        else begin : g_unused
            assign free_out[r] = '0;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.free_r0 = free_out[0];
    assign rsp.free_r1 = free_out[1];
    assign rsp.free_r2 = free_out[2];
    assign rsp.free_r3 = free_out[3];

endmodule

`default_nettype wire

/* tb/tb_bankers_resource_allocator_top.sv */
// ----------------------------------------------------------------------------
// tb_bankers_resource_allocator_top
// Self-checking bench for the banker's allocator. A ledger class keeps its own
// copy of the free pool, holdings and remaining needs, works out the status
// and free units of every command beat it sees accepted, and checks each
// response beat in order. Directed beats cover the edge cases: over claim,
// over free, unsafe denial, bad release, claim below holdings, and pool reset
// with holdings. Random command sequences follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_bankers_resource_allocator_top;
    import bra_pkg::*;

    localparam int UNIT_MAX   = (1 << UNIT_BITS_DEF) - 1;
    localparam int RAND_BEATS = 1400;
    localparam int GAP_MAX    = 18;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 60;

    typedef logic [UNIT_BITS_DEF-1:0] unit_t;
    typedef logic [AMT_W-1:0] amount_t;
    typedef logic [MAX_RTYPES-1:0][AMT_W-1:0] amounts_t;

    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] idx;
        amounts_t         amt;
    } cmd_beat_t;

    typedef struct packed {
        status_t  status;
        amounts_t free;
    } rsp_beat_t;

    class grant_ledger;
        logic [UNIT_BITS_DEF-1:0] free_units [RTYPES_DEF];
        logic [UNIT_BITS_DEF-1:0] held [CLIENTS_DEF][RTYPES_DEF];
        logic [UNIT_BITS_DEF-1:0] need [CLIENTS_DEF][RTYPES_DEF];
        rsp_beat_t                expected_responses [$];
        int                       errors;

        function new();
            foreach (free_units[r])
                free_units[r] = '0;
            foreach (held[c, r])
            begin
                held[c][r] = '0;
                need[c][r] = '0;
            end
            errors = 0;
        endfunction

        function int capped_sum(int a, int b);
            return (a + b > UNIT_MAX) ? UNIT_MAX : a + b;
        endfunction

        function int clamp_unit(int a);
            return (a > UNIT_MAX) ? UNIT_MAX : a;
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        function bit scan_is_safe();
            int work [RTYPES_DEF];
            bit done [CLIENTS_DEF];
            int left, p, c, r;
            bit progress, fits;
            foreach (work[i])
                work[i] = int'(free_units[i]);
            foreach (done[i])
                done[i] = 1'b0;
            left = CLIENTS_DEF;
            for (p = 0; p < CLIENTS_DEF && left > 0; p++)
            begin
                progress = 1'b0;
                for (c = 0; c < CLIENTS_DEF; c++)
                begin
                    if (!done[c])
                    begin
                        fits = 1'b1;
                        for (r = 0; r < RTYPES_DEF; r++)
                            if (need[c][r] > work[r])
                                fits = 1'b0;
                        if (fits)
                        begin
                            for (r = 0; r < RTYPES_DEF; r++)
                                work[r] = capped_sum(work[r], held[c][r]);
                            done[c] = 1'b1;
                            left--;
                            progress = 1'b1;
                        end
                    end
                end
                if (!progress)
                    break;
            end
            return left == 0;
        endfunction

        function status_t try_request(int c, amounts_t amt);
            int r;
            for (r = 0; r < RTYPES_DEF; r++)
                if (amt[r] > need[c][r])
                    return ST_OVER_CLAIM;
            for (r = 0; r < RTYPES_DEF; r++)
                if (amt[r] > free_units[r])
                    return ST_OVER_FREE;
            for (r = 0; r < RTYPES_DEF; r++)
            begin
                free_units[r] = free_units[r] - amt[r];
                held[c][r]    = unit_t'(capped_sum(held[c][r], amt[r]));
                need[c][r]    = need[c][r] - amt[r];
            end
            if (scan_is_safe())
                return ST_GRANTED;
            // roll the tentative grant back
            for (r = 0; r < RTYPES_DEF; r++)
            begin
                free_units[r] = unit_t'(capped_sum(free_units[r], amt[r]));
                held[c][r]    = held[c][r] - amt[r];
                need[c][r]    = unit_t'(capped_sum(need[c][r], amt[r]));
            end
            return ST_UNSAFE;
        endfunction

        function status_t give_back(int c, amounts_t amt);
            int r;
            for (r = 0; r < RTYPES_DEF; r++)
                if (amt[r] > held[c][r])
                    return ST_REJECTED;
            for (r = 0; r < RTYPES_DEF; r++)
            begin
                held[c][r]    = held[c][r] - amt[r];
                need[c][r]    = unit_t'(capped_sum(need[c][r], amt[r]));
                free_units[r] = unit_t'(capped_sum(free_units[r], amt[r]));
            end
            return ST_RELEASED;
        endfunction

        function status_t set_claim(int c, amounts_t amt);
            int r;
            for (r = 0; r < RTYPES_DEF; r++)
                if (clamp_unit(amt[r]) < held[c][r])
                    return ST_REJECTED;
            for (r = 0; r < RTYPES_DEF; r++)
                need[c][r] = unit_t'(clamp_unit(amt[r]) - int'(held[c][r]));
            return ST_CLAIM_SET;
        endfunction

        function status_t set_pool(amounts_t amt);
            int r;
            for (r = 0; r < RTYPES_DEF; r++)
                free_units[r] = unit_t'(clamp_unit(amt[r]));
            foreach (held[c, i])
            begin
                need[c][i] = unit_t'(capped_sum(need[c][i], held[c][i]));
                held[c][i] = '0;
            end
            return ST_POOL_SET;
        endfunction

        function void note_command(cmd_beat_t b);
            rsp_beat_t want;
            int        c, r;
            c = int'(b.idx);
            if (b.kind == KIND_POOL)
                want.status = set_pool(b.amt);
            else if (c >= CLIENTS_DEF)
                want.status = ST_REJECTED;
            else if (b.kind == KIND_REQUEST)
                want.status = try_request(c, b.amt);
            else if (b.kind == KIND_RELEASE)
                want.status = give_back(c, b.amt);
            else
                want.status = set_claim(c, b.amt);
            for (r = 0; r < MAX_RTYPES; r++)
                want.free[r] = (r < RTYPES_DEF) ? free_units[r] : '0;
            expected_responses.push_back(want);
        endfunction

        function void check_response(rsp_beat_t got);
            rsp_beat_t want;
            int        r;
            if (expected_responses.size() == 0)
            begin
                $error("response beat with no command outstanding");
                errors++;
                return;
            end
            want = expected_responses.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            for (r = 0; r < MAX_RTYPES; r++)
                if (got.free[r] !== want.free[r])
                begin
                    $error("free_r%0d: expected %0d, got %0d", r, want.free[r], got.free[r]);
                    errors++;
                end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   cmd_steady = 1'b0;
    bit   rsp_steady = 1'b0;
    int   idle_cycles = 0;
    grant_ledger ledger;

    bra_cmd_if cmd_ch ();
    bra_rsp_if rsp_ch ();

    bankers_resource_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic drive_command(cmd_beat_t b);
        int gap;
        if ($urandom_range(0, 39) == 0)
            cmd_steady = !cmd_steady;
        gap = cmd_steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.kind          <= b.kind;
        cmd_ch.process_index <= b.idx;
        cmd_ch.amount_r0     <= b.amt[0];
        cmd_ch.amount_r1     <= b.amt[1];
        cmd_ch.amount_r2     <= b.amt[2];
        cmd_ch.amount_r3     <= b.amt[3];
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        ledger.note_command(b);
    endtask

    task automatic send_fields(kind_t k, int c, int a0, int a1, int a2, int a3);
        cmd_beat_t b;
        b.kind   = k;
        b.idx    = c[IDX_W-1:0];
        b.amt[0] = a0[AMT_W-1:0];
        b.amt[1] = a1[AMT_W-1:0];
        b.amt[2] = a2[AMT_W-1:0];
        b.amt[3] = a3[AMT_W-1:0];
        drive_command(b);
    endtask

    task automatic wait_until_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() > 0)
            @(posedge clk);
    endtask

    // mostly well-formed traffic built from the ledger's view, some noise
    function automatic cmd_beat_t pick_command();
        cmd_beat_t b;
        int        sel, c, r, lim;
        bit        noise;
        sel   = $urandom_range(0, 99);
        c     = $urandom_range(0, CLIENTS_DEF - 1);
        noise = ($urandom_range(0, 7) == 0);
        b.idx = c[IDX_W-1:0];
        if (sel < 4)
        begin
            b.kind = KIND_POOL;
            for (r = 0; r < MAX_RTYPES; r++)
                b.amt[r] = amount_t'(noise ? $urandom_range(0, 255) : $urandom_range(4, 30));
        end
        else if (sel < 16)
        begin
            b.kind = KIND_CLAIM;
            for (r = 0; r < MAX_RTYPES; r++)
            begin
                lim = int'(ledger.held[c][r]) + int'($urandom_range(0, 14));
                b.amt[r] = amount_t'(noise ? int'($urandom_range(0, 255))
                                           : ((lim > 255) ? 255 : lim));
            end
        end
        else if (sel < 72)
        begin
            b.kind = KIND_REQUEST;
            for (r = 0; r < MAX_RTYPES; r++)
            begin
                lim = int'(ledger.need[c][r]);
                if ($urandom_range(0, 3) != 0 && ledger.free_units[r] < lim)
                    lim = int'(ledger.free_units[r]);
                b.amt[r] = amount_t'(noise ? $urandom_range(0, 255) : $urandom_range(0, lim));
            end
        end
        else
        begin
            b.kind = KIND_RELEASE;
            for (r = 0; r < MAX_RTYPES; r++)
                b.amt[r] = amount_t'(noise ? $urandom_range(0, 255)
                                           : $urandom_range(0, ledger.held[c][r]));
        end
        return b;
    endfunction

    initial
    begin
        rsp_beat_t got;
        int        gap;
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rsp_steady = !rsp_steady;
            gap = rsp_steady ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (rsp_ch.valid !== 1'b1)
                @(posedge clk);
            got.status  = status_t'(rsp_ch.status);
            got.free[0] = rsp_ch.free_r0;
            got.free[1] = rsp_ch.free_r1;
            got.free[2] = rsp_ch.free_r2;
            got.free[3] = rsp_ch.free_r3;
            ledger.check_response(got);
        end
    end

    initial
    begin
        int i;
        cmd_ch.valid         = 1'b0;
        cmd_ch.kind          = KIND_REQUEST;
        cmd_ch.process_index = '0;
        cmd_ch.amount_r0     = '0;
        cmd_ch.amount_r1     = '0;
        cmd_ch.amount_r2     = '0;
        cmd_ch.amount_r3     = '0;
        ledger = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // request against an empty claim
        send_fields(KIND_REQUEST, 0, 1, 0, 0, 0);
        send_fields(KIND_POOL,    0, 255, 255, 255, 255);
        send_fields(KIND_CLAIM,   0, 255, 255, 255, 255);
        send_fields(KIND_REQUEST, 0, 255, 255, 255, 255);
        send_fields(KIND_RELEASE, 0, 255, 255, 255, 255);
        send_fields(KIND_POOL,    1, 10, 10, 10, 10);
        send_fields(KIND_CLAIM,   0, 8, 8, 8, 8);
        send_fields(KIND_CLAIM,   1, 8, 8, 8, 8);
        send_fields(KIND_REQUEST, 0, 20, 0, 0, 0);
        send_fields(KIND_REQUEST, 0, 5, 0, 0, 0);
        // fits the claim but not the free units
        send_fields(KIND_REQUEST, 1, 6, 0, 0, 0);
        // leaves no safe order, must roll back
        send_fields(KIND_REQUEST, 1, 4, 0, 0, 0);
        send_fields(KIND_RELEASE, 0, 6, 0, 0, 0);
        send_fields(KIND_RELEASE, 0, 2, 0, 0, 0);
        // claim below holdings
        send_fields(KIND_CLAIM,   0, 1, 8, 8, 8);
        send_fields(KIND_CLAIM,   2, 170, 85, 15, 240);
        send_fields(KIND_CLAIM,   3, 85, 170, 240, 15);
        send_fields(KIND_REQUEST, 1, 2, 3, 4, 5);
        // pool reset while units are held
        send_fields(KIND_POOL,    2, 85, 170, 15, 240);
        send_fields(KIND_REQUEST, 0, 0, 0, 0, 0);
        send_fields(KIND_RELEASE, 3, 0, 0, 0, 0);
        send_fields(KIND_REQUEST, 2, 85, 85, 15, 15);
        send_fields(KIND_REQUEST, 3, 0, 85, 0, 225);
        wait_until_drained();

        for (i = 0; i < RAND_BEATS; i++)
        begin
            drive_command(pick_command());
            if (i == RAND_BEATS / 2)
                wait_until_drained();
        end
        wait_until_drained();
        repeat (SETTLE) @(posedge clk);

        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
